FILE: rtl/core/dhoat_pkg.sv
`timescale 1ns / 1ps
package dhoat_pkg;

  localparam int TableDepth = 64;
  localparam int IdxBits = $clog2(TableDepth);
  localparam int CntBits = 7;
  localparam int KeyBits = 64;
  localparam int DataBits = 32;
  localparam int HashBits = 32;
  localparam int MixShift = 16;
  localparam logic [31:0] MixMul = 32'h045d9f3b;
  localparam logic [31:0] Golden32 = 32'h61C88647;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_LOOKUP = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MARK_EMPTY = 2'd0,
    MARK_USED  = 2'd1,
    MARK_DEL   = 2'd2
  } mark_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIX1,
    S_MIX2,
    S_MIX3,
    S_READ,
    S_CHECK,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]          req_type;
    logic [KeyBits-1:0]  key;
    logic [HashBits-1:0] key_digest;
    logic [DataBits-1:0] data;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [DataBits-1:0] data_out;
    logic [CntBits-1:0]  entries_used;
  } rsp_t;

  typedef struct packed {
    logic                     rd_en;
    logic [IdxBits-1:0]       rd_addr;
    logic                     wr_en;
    logic                     wr_entry;
    logic [IdxBits-1:0]       wr_addr;
    mark_t                    wr_mark;
  } mem_ctl_t;

endpackage

FILE: rtl/core/double_hash_open_address_table.sv
`timescale 1ns / 1ps
// One request is handled at a time. A request passes through three mix states, then a read
// state and a check state per probed slot, since each probe waits on the registered read of the
// slot memory, and then an output state that loads the result register. The output state holds
// while an earlier result is still waiting, and the next item is accepted only back in idle. An
// unknown request type makes no probes. The slot marks are flip-flops cleared by reset, so no
// clearing pass is needed.
module double_hash_open_address_table (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  dhoat_pkg::req_t   in_item,
  output logic              out_valid,
  input  logic              out_ready,
  output dhoat_pkg::rsp_t   out_item
);
  import dhoat_pkg::*;

  mem_ctl_t ctl;
  logic [KeyBits-1:0] wr_key;
  logic [DataBits-1:0] wr_data;
  mark_t rd_mark;
  logic [KeyBits-1:0] rd_key;
  logic [DataBits-1:0] rd_data;

  dhoat_ctrl u_ctrl (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .ctl(ctl), .wr_key(wr_key), .wr_data(wr_data),
    .rd_mark(rd_mark), .rd_key(rd_key), .rd_data(rd_data)
  );

  dhoat_store u_store (
    .clk(clk), .rst(rst), .ctl(ctl), .wr_key(wr_key), .wr_data(wr_data),
    .rd_mark(rd_mark), .rd_key(rd_key), .rd_data(rd_data)
  );

`ifndef ASSERT_OFF
  a_no_rd_wr: assert property (@(posedge clk) disable iff (rst)
    !(ctl.rd_en && ctl.wr_en)) else $error("slot read and write in one cycle");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.entries_used <= CntBits'(TableDepth)))
    else $error("entry count above depth");
  a_in_out: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready) else $error("accepted while busy");
`endif

endmodule

FILE: rtl/core/dhoat_store.sv
`timescale 1ns / 1ps
module dhoat_store (
  input  logic                      clk,
  input  logic                      rst,
  input  dhoat_pkg::mem_ctl_t       ctl,
  input  logic [dhoat_pkg::KeyBits-1:0]  wr_key,
  input  logic [dhoat_pkg::DataBits-1:0] wr_data,
  output dhoat_pkg::mark_t          rd_mark,
  output logic [dhoat_pkg::KeyBits-1:0]  rd_key,
  output logic [dhoat_pkg::DataBits-1:0] rd_data
);
  import dhoat_pkg::*;

  logic [TableDepth-1:0] used;
  logic [TableDepth-1:0] del;
  logic [KeyBits-1:0]  key_mem [TableDepth];
  logic [DataBits-1:0] data_mem [TableDepth];

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
      del <= '0;
    end else if (ctl.wr_en) begin
      used[ctl.wr_addr] <= (ctl.wr_mark == MARK_USED);
      del[ctl.wr_addr] <= (ctl.wr_mark == MARK_DEL);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_entry) begin
      key_mem[ctl.wr_addr] <= wr_key;
      data_mem[ctl.wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_key <= key_mem[ctl.rd_addr];
      rd_data <= data_mem[ctl.rd_addr];
      rd_mark <= used[ctl.rd_addr] ? MARK_USED :
                 (del[ctl.rd_addr] ? MARK_DEL : MARK_EMPTY);
    end
  end

endmodule

FILE: rtl/core/dhoat_ctrl.sv
`timescale 1ns / 1ps
module dhoat_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  dhoat_pkg::req_t       in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output dhoat_pkg::rsp_t       out_item,
  output dhoat_pkg::mem_ctl_t   ctl,
  output logic [dhoat_pkg::KeyBits-1:0]  wr_key,
  output logic [dhoat_pkg::DataBits-1:0] wr_data,
  input  dhoat_pkg::mark_t      rd_mark,
  input  logic [dhoat_pkg::KeyBits-1:0]  rd_key,
  input  logic [dhoat_pkg::DataBits-1:0] rd_data
);
  import dhoat_pkg::*;

  state_t state, state_next;
  req_t req;
  logic [31:0] mixv;
  logic [IdxBits-1:0] idx;
  logic [IdxBits-1:0] step;
  logic [IdxBits:0] probes;
  logic [CntBits-1:0] count;
  rsp_t rsp;
  logic [31:0] mix_in;
  logic [31:0] step_full;
  logic hit;
  logic stop;

  assign mix_in = (mixv >> MixShift) ^ mixv;
  assign step_full = req.key_digest * Golden32;
  assign hit = (rd_mark == MARK_USED) && (rd_key == req.key);

  always_comb begin
    stop = 1'b0;
    if (req.req_type == REQ_INSERT) begin
      stop = (rd_mark != MARK_USED) || (probes == (IdxBits + 1)'(TableDepth - 1));
    end else begin
      stop = (rd_mark == MARK_EMPTY) || hit ||
             (probes == (IdxBits + 1)'(TableDepth - 1));
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_MIX1;
      S_MIX1: state_next = S_MIX2;
      S_MIX2: state_next = S_MIX3;
      S_MIX3: state_next = (req.req_type == REQ_NONE) ? S_OUT : S_READ;
      S_READ: state_next = S_CHECK;
      S_CHECK: state_next = stop ? S_OUT : S_READ;
      S_OUT: if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    ctl = '0;
    ctl.wr_mark = MARK_EMPTY;
    ctl.rd_en = (state == S_READ);
    ctl.rd_addr = idx;
    ctl.wr_addr = idx;
    if (state == S_CHECK) begin
      if (req.req_type == REQ_INSERT && rd_mark != MARK_USED) begin
        ctl.wr_en = 1'b1;
        ctl.wr_entry = 1'b1;
        ctl.wr_mark = MARK_USED;
      end else if (req.req_type == REQ_DELETE && hit) begin
        ctl.wr_en = 1'b1;
        ctl.wr_mark = MARK_DEL;
      end
    end
    wr_key = req.key;
    wr_data = req.data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && state_next == S_IDLE) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (ctl.wr_en && ctl.wr_entry) count <= count + 1'b1;
      if (ctl.wr_en && !ctl.wr_entry && count != '0) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          req <= in_item;
          mixv <= in_item.key_digest;
        end
      end
      S_MIX1: mixv <= mix_in * MixMul;
      S_MIX2: begin
        mixv <= mix_in * MixMul;
        step <= step_full[IdxBits-1:0];
      end
      S_MIX3: begin
        idx <= mix_in[IdxBits-1:0];
        probes <= '0;
        rsp.status <= (req.req_type == REQ_INSERT) ? ST_FULL : ST_NOTFOUND;
        rsp.data_out <= '0;
      end
      S_CHECK: begin
        idx <= idx + step;
        probes <= probes + 1'b1;
        if (req.req_type == REQ_INSERT && rd_mark != MARK_USED) begin
          rsp.status <= ST_DONE;
        end else if (req.req_type != REQ_INSERT && hit) begin
          rsp.status <= ST_DONE;
          if (req.req_type == REQ_LOOKUP) rsp.data_out <= rd_data;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && state_next == S_IDLE) begin
      out_item.status <= rsp.status;
      out_item.data_out <= rsp.data_out;
      out_item.entries_used <= count;
    end
  end

endmodule

FILE: tb/double_hash_open_address_table_test.sv
`timescale 1ns / 1ps
module double_hash_open_address_table_test;
  import dhoat_pkg::*;

  localparam int MaxCycles = 2000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  req_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  rsp_t out_item;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];

  // Shadow copy of the table used for prediction.
  mark_t shadow_mark[TableDepth];
  logic [KeyBits-1:0] shadow_key[TableDepth];
  logic [DataBits-1:0] shadow_data[TableDepth];
  logic [CntBits-1:0] shadow_count;

  // Keys sent in insert requests, for directing deletes and lookups.
  logic [KeyBits-1:0] live_keys[$];
  logic [HashBits-1:0] live_hashes[$];

  int mismatches = 0;
  int unexpected = 0;
  int cycle_count = 0;
  int rsps_seen = 0;
  int hits = 0;
  int fulls = 0;
  bit stimulus_done = 1'b0;
  bit hold_off = 1'b0;
  int gap_left = 0;
  int stall_left = 0;

  double_hash_open_address_table i_dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item(out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic [31:0] mix_hash(logic [31:0] v);
    logic [31:0] x;
    x = ((v >> MixShift) ^ v) * MixMul;
    x = ((x >> MixShift) ^ x) * MixMul;
    return (x >> MixShift) ^ x;
  endfunction

  function automatic rsp_t predict_table(req_t r);
    rsp_t rsp;
    logic [31:0] pos;
    logic [31:0] stride;
    logic [31:0] prod;
    pos = mix_hash(r.key_digest) % TableDepth;
    prod = r.key_digest * Golden32;
    stride = prod % TableDepth;
    rsp.status = ST_NOTFOUND;
    rsp.data_out = '0;
    if (r.req_type == REQ_INSERT) begin
      rsp.status = ST_FULL;
      for (int i = 0; i < TableDepth; i++) begin
        if (shadow_mark[pos] != MARK_USED) begin
          shadow_mark[pos] = MARK_USED;
          shadow_key[pos] = r.key;
          shadow_data[pos] = r.data;
          shadow_count++;
          rsp.status = ST_DONE;
          break;
        end
        pos = (pos + stride) % TableDepth;
      end
    end else if (r.req_type == REQ_DELETE || r.req_type == REQ_LOOKUP) begin
      for (int i = 0; i < TableDepth; i++) begin
        if (shadow_mark[pos] == MARK_EMPTY) break;
        if (shadow_mark[pos] == MARK_USED && shadow_key[pos] == r.key) begin
          rsp.status = ST_DONE;
          if (r.req_type == REQ_DELETE) begin
            shadow_mark[pos] = MARK_DEL;
            if (shadow_count > 0) shadow_count--;
          end else begin
            rsp.data_out = shadow_data[pos];
          end
          break;
        end
        pos = (pos + stride) % TableDepth;
      end
    end
    rsp.entries_used = shadow_count;
    return rsp;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic add_req(logic [1:0] kind, logic [KeyBits-1:0] k, logic [HashBits-1:0] h,
                         logic [DataBits-1:0] d);
    req_t r;
    r.req_type = kind;
    r.key = k;
    r.key_digest = h;
    r.data = d;
    pending_reqs.push_back(r);
    if (kind == REQ_INSERT) begin
      live_keys.push_back(k);
      live_hashes.push_back(h);
    end
  endtask

  // Picks a key used before, so that deletes and lookups mostly hit.
  task automatic add_known(logic [1:0] kind);
    int j;
    if (live_keys.size() == 0) begin
      add_req(kind, rand64(), $urandom(), $urandom());
    end else begin
      j = $urandom_range(live_keys.size() - 1);
      add_req(kind, live_keys[j], live_hashes[j], $urandom());
    end
  endtask

  function automatic int pick_gap();
    int p;
    p = $urandom_range(99);
    if (p < 50) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (!rst) begin
      if (in_valid && in_ready) begin
        expected_rsps.push_back(predict_table(in_item));
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          in_item <= pending_reqs.pop_front();
          in_valid <= 1'b1;
          gap_left <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        rsps_seen <= rsps_seen + 1;
        if (expected_rsps.size() == 0) begin
          unexpected++;
          $display("Unexpected item at cycle %0d: %p", cycle_count, out_item);
        end else begin
          rsp_t exp_rsp;
          exp_rsp = expected_rsps.pop_front();
          if (exp_rsp.status == ST_DONE && exp_rsp.data_out != 0) hits <= hits + 1;
          if (exp_rsp.status == ST_FULL) fulls <= fulls + 1;
          if (out_item.status !== exp_rsp.status || out_item.data_out !== exp_rsp.data_out ||
              out_item.entries_used !== exp_rsp.entries_used) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch at cycle %0d: expected %0d %h %0d, got %0d %h %0d",
                       cycle_count, exp_rsp.status, exp_rsp.data_out, exp_rsp.entries_used,
                       out_item.status, out_item.data_out, out_item.entries_used);
            end
          end
        end
      end
      if (hold_off) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        stall_left <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count >= MaxCycles) begin
      $display("Timeout at cycle %0d", cycle_count);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int phase_len;
    int p;
    for (int i = 0; i < TableDepth; i++) begin
      shadow_mark[i] = MARK_EMPTY;
      shadow_key[i] = '0;
      shadow_data[i] = '0;
    end
    shadow_count = '0;

    // Directed: lookups and deletes on an empty table, field extremes, the unused type.
    add_req(REQ_LOOKUP, '0, '0, '0);
    add_req(REQ_DELETE, '1, '1, '1);
    add_req(REQ_INSERT, '0, '0, '0);
    add_req(REQ_INSERT, '1, '1, '1);
    add_req(REQ_INSERT, 64'h5555_5555_5555_5555, 32'h0000_0040, 32'hAAAA_AAAA);
    add_req(REQ_LOOKUP, '1, '1, '0);
    add_req(REQ_LOOKUP, '0, '0, '1);
    add_req(REQ_NONE, '1, '1, '1);
    // A hash whose stride is zero revisits the home slot only.
    add_req(REQ_INSERT, 64'h1, 32'h0000_0040, 32'h1234_5678);
    add_req(REQ_LOOKUP, 64'h1, 32'h0000_0040, '0);
    // Deleting leaves a tombstone that later lookups walk past.
    add_req(REQ_DELETE, 64'h5555_5555_5555_5555, 32'h0000_0040, '0);
    add_req(REQ_LOOKUP, 64'h1, 32'h0000_0040, '0);
    add_req(REQ_INSERT, 64'h2, 32'h0000_0040, 32'hCAFE_0001);
    add_req(REQ_LOOKUP, 64'h2, 32'h0000_0040, '0);
    add_req(REQ_DELETE, 64'h9, 32'h0000_0040, '0);
    add_req(REQ_INSERT, 64'h0, 32'h0, 32'h7);
    add_req(REQ_DELETE, 64'h0, 32'h0, '0);
    add_req(REQ_LOOKUP, 64'h0, 32'h0, '0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Each random phase favours inserts, favours deletes, or mixes all request types with the unused one.
    while (pending_reqs.size() + 18 < 1020) begin
      phase_len = $urandom_range(120, 30);
      p = $urandom_range(3);
      for (int i = 0; i < phase_len; i++) begin
        int r;
        r = $urandom_range(99);
        if (p == 0) begin
          if (r < 75) add_req(REQ_INSERT, rand64(), $urandom(), $urandom());
          else if (r < 90) add_known(REQ_LOOKUP);
          else add_known(REQ_DELETE);
        end else if (p == 1) begin
          if (r < 55) add_known(REQ_DELETE);
          else if (r < 85) add_known(REQ_LOOKUP);
          else add_req(REQ_INSERT, rand64(), $urandom(), $urandom());
        end else begin
          if (r < 35) add_req(REQ_INSERT, rand64(), $urandom(), $urandom());
          else if (r < 60) add_known(REQ_LOOKUP);
          else if (r < 85) add_known(REQ_DELETE);
          else if (r < 95) add_req(2'($urandom_range(2)), rand64(), $urandom(), $urandom());
          else add_req(REQ_NONE, rand64(), $urandom(), $urandom());
        end
      end
    end

    // Hold the output off long enough for the block to stall its input.
    wait (rsps_seen > 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (200) @(posedge clk);
    hold_off <= 1'b0;

    wait (pending_reqs.size() == 0 && !in_valid);
    wait (expected_rsps.size() == 0);
    repeat (300) @(posedge clk);

    $display("Run covered %0d results, %0d lookups with nonzero data, %0d full-table inserts.",
             rsps_seen, hits, fulls);
    if (mismatches == 0 && unexpected == 0 && expected_rsps.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/core/dhoat_pkg.sv
rtl/core/dhoat_store.sv
rtl/core/dhoat_ctrl.sv
rtl/core/double_hash_open_address_table.sv
tb/double_hash_open_address_table_test.sv
